### rtl/sat_pkg.sv
// Shared types, sizes and codes of the sorted array table.
// Used by the controller, datapath and top level; depends on nothing else.
`default_nettype none

package sat_pkg;

    // Storage sizing.
    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed widths of the beat fields.
    localparam int ACT_W       = 3;
    localparam int IDX_W       = 7;
    localparam int FIELD_VAL_W = 32;
    localparam int STATUS_W    = 3;

    // Width of positions that must hold both an index field and the count.
    localparam int POS_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SORTED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = CFG_IDX_W'(2);

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_READ      = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_OVERWRITE = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_INSERT    = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_APPEND    = ACT_W'(3);
    localparam logic [ACT_W-1:0] ACT_ADD       = ACT_W'(4);
    localparam logic [ACT_W-1:0] ACT_REMOVE    = ACT_W'(5);
    localparam logic [ACT_W-1:0] ACT_FIND      = ACT_W'(6);

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK            = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_RANGE         = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_DUPLICATE     = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_FULL          = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND     = STATUS_W'(4);
    localparam logic [STATUS_W-1:0] ST_APPEND_SORTED = STATUS_W'(5);

    // Datapath micro-operations issued by the controller.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE      = OP_W'(0);
    localparam logic [OP_W-1:0] OP_LOAD      = OP_W'(1);
    localparam logic [OP_W-1:0] OP_SRCH_INIT = OP_W'(2);
    localparam logic [OP_W-1:0] OP_SRCH_RD   = OP_W'(3);
    localparam logic [OP_W-1:0] OP_SRCH_STEP = OP_W'(4);
    localparam logic [OP_W-1:0] OP_POS_RD    = OP_W'(5);
    localparam logic [OP_W-1:0] OP_SCAN_NEXT = OP_W'(6);
    localparam logic [OP_W-1:0] OP_INS_INIT  = OP_W'(7);
    localparam logic [OP_W-1:0] OP_SHUP_INIT = OP_W'(8);
    localparam logic [OP_W-1:0] OP_SHUP_RD   = OP_W'(9);
    localparam logic [OP_W-1:0] OP_SHUP_WR   = OP_W'(10);
    localparam logic [OP_W-1:0] OP_INS_WR    = OP_W'(11);
    localparam logic [OP_W-1:0] OP_SHDN_INIT = OP_W'(12);
    localparam logic [OP_W-1:0] OP_SHDN_RD   = OP_W'(13);
    localparam logic [OP_W-1:0] OP_SHDN_WR   = OP_W'(14);
    localparam logic [OP_W-1:0] OP_REM_DONE  = OP_W'(15);
    localparam logic [OP_W-1:0] OP_RD_IDX    = OP_W'(16);
    localparam logic [OP_W-1:0] OP_RD_DONE   = OP_W'(17);
    localparam logic [OP_W-1:0] OP_WR_IDX    = OP_W'(18);
    localparam logic [OP_W-1:0] OP_WR_POS    = OP_W'(19);
    localparam logic [OP_W-1:0] OP_APPEND    = OP_W'(20);
    localparam logic [OP_W-1:0] OP_EMIT_ZERO = OP_W'(21);
    localparam logic [OP_W-1:0] OP_EMIT_POS  = OP_W'(22);

    typedef struct packed {
        logic [ACT_W-1:0]       action;
        logic [IDX_W-1:0]       index;
        logic [FIELD_VAL_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [IDX_W-1:0]       result_index;
        logic [FIELD_VAL_W-1:0] read_value;
        logic [IDX_W-1:0]       entry_count_out;
    } rsp_item_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             idx_ge_cnt;
        logic             idx_gt_cnt;
        logic             full;
        logic             sorted;
        logic             unique_on;
        logic             lo_lt_hi;
        logic             lo_lt_cnt;
        logic             rd_eq;
        logic             shup_more;
        logic             shdn_more;
        logic             out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/sorted_array_table.sv
// Top level of the sorted array table: controller, datapath and entry RAM.
// Depends on sat_pkg, sat_ctrl, sat_dp and sat_ram.
//
// Usage:
//   Request beats (req_valid, req_stall, req_item) carry an action, an index
//   and a value; each accepted beat yields exactly one response beat
//   (rsp_valid, rsp_stall, rsp_item) with status, result index, read value and
//   the entry count after the action. The block works on one request at a time
//   and holds req_stall high until it is idle again, so it takes no new request
//   before the response to the last one is loaded. A dispatch step checks each
//   request; errors, overwrite, append, unsorted add and the unused code respond
//   from it. A read adds a RAM read step; insert and remove shift entries one
//   by one; find scans (unsorted) or binary-searches (sorted) and then checks
//   the position found; a sorted add that inserts then shifts like an insert.
//   Each moved entry is read and then written back in the next cycle. A step
//   that produces a response waits while the output register holds a stalled
//   one; the next request is taken in the cycle after the response is loaded.
//   Configuration writes (cfg_valid, cfg_ready always high) set the modes;
//   issue them only while the block is idle. Reset clears the entry count, the
//   modes and the output valid; entry contents are never read before written.
`default_nettype none

module sorted_array_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire sat_pkg::req_item_t            req_item,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output sat_pkg::rsp_item_t                 rsp_item,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                          cfg_data
);

    sat_pkg::dp_cmd_t    cmd;
    sat_pkg::dp_status_t sts;

    // Registers are plain flops; a write always lands in its cycle.
    assign cfg_ready = 1'b1;

    sat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sat_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .rsp_item  (rsp_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

### rtl/sat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/sat_ctrl.sv
// Controller state machine of the sorted array table.
// Depends on sat_pkg; drives micro-operations into sat_dp.
`default_nettype none

module sat_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire sat_pkg::dp_status_t sts,
    output sat_pkg::dp_cmd_t         cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE      = ST_W'(0);
    localparam logic [ST_W-1:0] S_DISP      = ST_W'(1);
    localparam logic [ST_W-1:0] S_BS        = ST_W'(2);
    localparam logic [ST_W-1:0] S_BS_STEP   = ST_W'(3);
    localparam logic [ST_W-1:0] S_BS_CHK    = ST_W'(4);
    localparam logic [ST_W-1:0] S_SCAN      = ST_W'(5);
    localparam logic [ST_W-1:0] S_SCAN_STEP = ST_W'(6);
    localparam logic [ST_W-1:0] S_SHUP      = ST_W'(7);
    localparam logic [ST_W-1:0] S_SHUP_WR   = ST_W'(8);
    localparam logic [ST_W-1:0] S_SHDN      = ST_W'(9);
    localparam logic [ST_W-1:0] S_SHDN_WR   = ST_W'(10);
    localparam logic [ST_W-1:0] S_RD_DONE   = ST_W'(11);

    logic [ST_W-1:0]              state_reg;
    logic [ST_W-1:0]              state_next;
    logic [ST_W-1:0]              state_c;
    logic [sat_pkg::OP_W-1:0]     op_c;
    logic [sat_pkg::STATUS_W-1:0] status_c;
    logic                         emits_c;

    // Outcome of a search once the position is known.
    logic                         found_w;
    logic [ST_W-1:0]              res_state;
    logic [sat_pkg::OP_W-1:0]     res_op;
    logic [sat_pkg::STATUS_W-1:0] res_status;
    logic                         res_emits;

    assign found_w = ((state_reg == S_BS_CHK) || (state_reg == S_SCAN_STEP)) && sts.rd_eq;

    always_comb
    begin
        res_state  = S_IDLE;
        res_op     = sat_pkg::OP_EMIT_POS;
        res_status = sat_pkg::ST_OK;
        res_emits  = 1'b1;
        if (sts.act == sat_pkg::ACT_FIND)
        begin
            res_status = found_w ? sat_pkg::ST_OK : sat_pkg::ST_NOT_FOUND;
        end
        else if (found_w)
        begin
            if (sts.unique_on)
            begin
                res_status = sat_pkg::ST_DUPLICATE;
            end
            else
            begin
                res_op = sat_pkg::OP_WR_POS;
            end
        end
        else if (sts.full)
        begin
            res_op     = sat_pkg::OP_EMIT_ZERO;
            res_status = sat_pkg::ST_FULL;
        end
        else
        begin
            res_op    = sat_pkg::OP_SHUP_INIT;
            res_state = S_SHUP;
            res_emits = 1'b0;
        end
    end

    always_comb
    begin
        state_c  = state_reg;
        op_c     = sat_pkg::OP_NONE;
        status_c = sat_pkg::ST_OK;
        emits_c  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_c    = sat_pkg::OP_LOAD;
                    state_c = S_DISP;
                end
            end
            S_DISP:
            begin
                state_c = S_IDLE;
                case (sts.act)
                    sat_pkg::ACT_READ:
                    begin
                        if (sts.idx_ge_cnt)
                        begin
                            op_c     = sat_pkg::OP_EMIT_ZERO;
                            status_c = sat_pkg::ST_RANGE;
                            emits_c  = 1'b1;
                        end
                        else
                        begin
                            op_c    = sat_pkg::OP_RD_IDX;
                            state_c = S_RD_DONE;
                        end
                    end
                    sat_pkg::ACT_OVERWRITE:
                    begin
                        emits_c = 1'b1;
                        if (sts.idx_ge_cnt)
                        begin
                            op_c     = sat_pkg::OP_EMIT_ZERO;
                            status_c = sat_pkg::ST_RANGE;
                        end
                        else
                        begin
                            op_c = sat_pkg::OP_WR_IDX;
                        end
                    end
                    sat_pkg::ACT_INSERT:
                    begin
                        if (sts.idx_gt_cnt || sts.full)
                        begin
                            op_c     = sat_pkg::OP_EMIT_ZERO;
                            status_c = sts.idx_gt_cnt ? sat_pkg::ST_RANGE : sat_pkg::ST_FULL;
                            emits_c  = 1'b1;
                        end
                        else
                        begin
                            op_c    = sat_pkg::OP_INS_INIT;
                            state_c = S_SHUP;
                        end
                    end
                    sat_pkg::ACT_APPEND,
                    sat_pkg::ACT_ADD:
                    begin
                        if (sts.sorted && (sts.act == sat_pkg::ACT_APPEND))
                        begin
                            op_c     = sat_pkg::OP_EMIT_ZERO;
                            status_c = sat_pkg::ST_APPEND_SORTED;
                            emits_c  = 1'b1;
                        end
                        else if (sts.sorted)
                        begin
                            op_c    = sat_pkg::OP_SRCH_INIT;
                            state_c = S_BS;
                        end
                        else if (sts.full)
                        begin
                            op_c     = sat_pkg::OP_EMIT_ZERO;
                            status_c = sat_pkg::ST_FULL;
                            emits_c  = 1'b1;
                        end
                        else
                        begin
                            op_c    = sat_pkg::OP_APPEND;
                            emits_c = 1'b1;
                        end
                    end
                    sat_pkg::ACT_REMOVE:
                    begin
                        if (sts.idx_ge_cnt)
                        begin
                            op_c     = sat_pkg::OP_EMIT_ZERO;
                            status_c = sat_pkg::ST_RANGE;
                            emits_c  = 1'b1;
                        end
                        else
                        begin
                            op_c    = sat_pkg::OP_SHDN_INIT;
                            state_c = S_SHDN;
                        end
                    end
                    sat_pkg::ACT_FIND:
                    begin
                        op_c    = sat_pkg::OP_SRCH_INIT;
                        state_c = sts.sorted ? S_BS : S_SCAN;
                    end
                    default:
                    begin
                        // Unused action code: no change, plain ok result.
                        op_c    = sat_pkg::OP_EMIT_ZERO;
                        emits_c = 1'b1;
                    end
                endcase
            end
            S_BS:
            begin
                if (sts.lo_lt_hi)
                begin
                    op_c    = sat_pkg::OP_SRCH_RD;
                    state_c = S_BS_STEP;
                end
                else if (sts.lo_lt_cnt)
                begin
                    op_c    = sat_pkg::OP_POS_RD;
                    state_c = S_BS_CHK;
                end
                else
                begin
                    op_c     = res_op;
                    status_c = res_status;
                    state_c  = res_state;
                    emits_c  = res_emits;
                end
            end
            S_BS_STEP:
            begin
                op_c    = sat_pkg::OP_SRCH_STEP;
                state_c = S_BS;
            end
            S_BS_CHK:
            begin
                op_c     = res_op;
                status_c = res_status;
                state_c  = res_state;
                emits_c  = res_emits;
            end
            S_SCAN:
            begin
                if (sts.lo_lt_cnt)
                begin
                    op_c    = sat_pkg::OP_POS_RD;
                    state_c = S_SCAN_STEP;
                end
                else
                begin
                    op_c     = res_op;
                    status_c = res_status;
                    state_c  = res_state;
                    emits_c  = res_emits;
                end
            end
            S_SCAN_STEP:
            begin
                if (sts.rd_eq)
                begin
                    op_c     = res_op;
                    status_c = res_status;
                    state_c  = res_state;
                    emits_c  = res_emits;
                end
                else
                begin
                    op_c    = sat_pkg::OP_SCAN_NEXT;
                    state_c = S_SCAN;
                end
            end
            S_SHUP:
            begin
                if (sts.shup_more)
                begin
                    op_c    = sat_pkg::OP_SHUP_RD;
                    state_c = S_SHUP_WR;
                end
                else
                begin
                    op_c    = sat_pkg::OP_INS_WR;
                    emits_c = 1'b1;
                    state_c = S_IDLE;
                end
            end
            S_SHUP_WR:
            begin
                op_c    = sat_pkg::OP_SHUP_WR;
                state_c = S_SHUP;
            end
            S_SHDN:
            begin
                if (sts.shdn_more)
                begin
                    op_c    = sat_pkg::OP_SHDN_RD;
                    state_c = S_SHDN_WR;
                end
                else
                begin
                    op_c    = sat_pkg::OP_REM_DONE;
                    emits_c = 1'b1;
                    state_c = S_IDLE;
                end
            end
            S_SHDN_WR:
            begin
                op_c    = sat_pkg::OP_SHDN_WR;
                state_c = S_SHDN;
            end
            S_RD_DONE:
            begin
                op_c    = sat_pkg::OP_RD_DONE;
                emits_c = 1'b1;
                state_c = S_IDLE;
            end
            default:
            begin
                state_c = S_IDLE;
            end
        endcase
    end

    // A step that produces the result waits while the output register holds a result the receiver stalls.
    always_comb
    begin
        cmd.op     = op_c;
        cmd.status = status_c;
        state_next = state_c;
        if (emits_c && !sts.out_free)
        begin
            cmd.op     = sat_pkg::OP_NONE;
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

### rtl/sat_dp.sv
// Datapath of the sorted array table: operands, count, search bounds,
// shift pointer, configuration and the result register. Depends on sat_pkg and sat_ram.
`default_nettype none

module sat_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sat_pkg::req_item_t                 req_item,
    output sat_pkg::rsp_item_t                      rsp_item,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    input  wire logic                               cfg_valid,
    input  wire logic [sat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic                               cfg_data,
    input  wire sat_pkg::dp_cmd_t                   cmd,
    output sat_pkg::dp_status_t                     sts
);

    localparam int PW = sat_pkg::POS_W;
    localparam int VW = sat_pkg::VALUE_WIDTH;
    localparam int AW = sat_pkg::ADDR_W;

    logic [sat_pkg::ACT_W-1:0] act_reg, act_next;
    logic [PW-1:0]             idx_reg, idx_next;
    logic [VW-1:0]             val_reg, val_next;
    logic [sat_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]             lo_reg, lo_next;
    logic [PW-1:0]             hi_reg, hi_next;
    logic [PW-1:0]             ptr_reg, ptr_next;
    logic                      sorted_reg, unique_reg, signed_reg;
    logic                      rsp_valid_reg, rsp_valid_next;
    sat_pkg::rsp_item_t        rsp_item_reg, emit_item;
    logic                      emit;

    logic [PW-1:0] cnt_ext;
    logic [PW:0]   mid_sum;
    logic [PW-1:0] mid;
    logic [PW-1:0] ptr_dec;
    logic [PW-1:0] ptr_inc;
    logic [VW-1:0] sign_flip;
    logic          rd_less;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_wdata, ram_rdata;

    sat_ram #(
        .WIDTH (VW),
        .DEPTH (sat_pkg::TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_ext   = PW'(cnt_reg);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[PW:1];
    assign ptr_dec   = ptr_reg - PW'(1);
    assign ptr_inc   = ptr_reg + PW'(1);
    // Two's complement order is unsigned order with the sign bits inverted.
    assign sign_flip = VW'(signed_reg) << (VW - 1);
    assign rd_less   = (ram_rdata ^ sign_flip) < (val_reg ^ sign_flip);

    always_comb
    begin
        act_next  = act_reg;
        idx_next  = idx_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        ptr_next  = ptr_reg;
        ram_we    = 1'b0;
        ram_waddr = lo_reg[AW-1:0];
        ram_wdata = val_reg;
        ram_re    = 1'b0;
        ram_raddr = lo_reg[AW-1:0];
        emit      = 1'b0;
        emit_item.status       = cmd.status;
        emit_item.result_index = '0;
        emit_item.read_value   = '0;
        case (cmd.op)
            sat_pkg::OP_LOAD:
            begin
                act_next = req_item.action;
                idx_next = PW'(req_item.index);
                val_next = VW'(req_item.value);
            end
            sat_pkg::OP_SRCH_INIT:
            begin
                lo_next = '0;
                hi_next = cnt_ext;
            end
            sat_pkg::OP_SRCH_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = mid[AW-1:0];
            end
            sat_pkg::OP_SRCH_STEP:
            begin
                if (rd_less)
                begin
                    lo_next = mid + PW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
            end
            sat_pkg::OP_POS_RD:
            begin
                ram_re = 1'b1;
            end
            sat_pkg::OP_SCAN_NEXT:
            begin
                lo_next = lo_reg + PW'(1);
            end
            sat_pkg::OP_INS_INIT:
            begin
                lo_next  = idx_reg;
                ptr_next = cnt_ext;
            end
            sat_pkg::OP_SHUP_INIT:
            begin
                ptr_next = cnt_ext;
            end
            sat_pkg::OP_SHUP_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = ptr_dec[AW-1:0];
            end
            sat_pkg::OP_SHUP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[AW-1:0];
                ram_wdata = ram_rdata;
                ptr_next  = ptr_dec;
            end
            sat_pkg::OP_INS_WR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + sat_pkg::CNT_W'(1);
                emit     = 1'b1;
                emit_item.result_index = sat_pkg::IDX_W'(lo_reg);
            end
            sat_pkg::OP_SHDN_INIT:
            begin
                ptr_next = idx_reg;
            end
            sat_pkg::OP_SHDN_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = ptr_inc[AW-1:0];
            end
            sat_pkg::OP_SHDN_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[AW-1:0];
                ram_wdata = ram_rdata;
                ptr_next  = ptr_inc;
            end
            sat_pkg::OP_REM_DONE:
            begin
                cnt_next = cnt_reg - sat_pkg::CNT_W'(1);
                emit     = 1'b1;
                emit_item.result_index = sat_pkg::IDX_W'(idx_reg);
            end
            sat_pkg::OP_RD_IDX:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg[AW-1:0];
            end
            sat_pkg::OP_RD_DONE:
            begin
                emit = 1'b1;
                emit_item.result_index = sat_pkg::IDX_W'(idx_reg);
                emit_item.read_value   = sat_pkg::FIELD_VAL_W'(ram_rdata);
            end
            sat_pkg::OP_WR_IDX:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                emit      = 1'b1;
                emit_item.result_index = sat_pkg::IDX_W'(idx_reg);
            end
            sat_pkg::OP_WR_POS:
            begin
                ram_we = 1'b1;
                emit   = 1'b1;
                emit_item.result_index = sat_pkg::IDX_W'(lo_reg);
            end
            sat_pkg::OP_APPEND:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                cnt_next  = cnt_reg + sat_pkg::CNT_W'(1);
                emit      = 1'b1;
                emit_item.result_index = sat_pkg::IDX_W'(cnt_reg);
            end
            sat_pkg::OP_EMIT_ZERO:
            begin
                emit = 1'b1;
            end
            sat_pkg::OP_EMIT_POS:
            begin
                emit = 1'b1;
                emit_item.result_index = sat_pkg::IDX_W'(lo_reg);
            end
            default:
            begin
            end
        endcase
        emit_item.entry_count_out = sat_pkg::IDX_W'(cnt_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            sorted_reg    <= 1'b0;
            unique_reg    <= 1'b0;
            signed_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    sat_pkg::CFG_SORTED: sorted_reg <= cfg_data;
                    sat_pkg::CFG_UNIQUE: unique_reg <= cfg_data;
                    sat_pkg::CFG_SIGNED: signed_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        ptr_reg <= ptr_next;
        if (emit)
        begin
            rsp_item_reg <= emit_item;
        end
    end

    assign sts.act        = act_reg;
    assign sts.idx_ge_cnt = (idx_reg >= cnt_ext);
    assign sts.idx_gt_cnt = (idx_reg > cnt_ext);
    assign sts.full       = (cnt_reg >= sat_pkg::CNT_W'(sat_pkg::TABLE_DEPTH));
    assign sts.sorted     = sorted_reg;
    assign sts.unique_on  = unique_reg;
    assign sts.lo_lt_hi   = (lo_reg < hi_reg);
    assign sts.lo_lt_cnt  = (lo_reg < cnt_ext);
    assign sts.rd_eq      = (ram_rdata == val_reg);
    assign sts.shup_more  = (ptr_reg > lo_reg);
    assign sts.shdn_more  = (ptr_inc < cnt_ext);
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // The count never passes the table depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sat_pkg::CNT_W'(sat_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    // A result is never loaded over one that is still held by the receiver.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(rsp_valid_reg && rsp_stall))
        else $error("result register overrun");

    // The count moves only with the step that delivers the result.
    a_cnt_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> $past(emit))
        else $error("entry count changed without a result");

    // Binary search steps only run on a non-empty interval.
    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == sat_pkg::OP_SRCH_STEP) |-> (lo_reg < hi_reg))
        else $error("search step on empty interval");

    // Upward shift writes stay inside the occupied part plus one free slot.
    a_shift_up_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == sat_pkg::OP_SHUP_WR) |-> (ptr_reg <= cnt_ext && ptr_reg > lo_reg))
        else $error("shift-up write out of range");

endmodule

`default_nettype wire

### test/tb_sorted_array_table.sv
// Self-checking testbench for sorted_array_table: drives request beats, writes the modes
// between phases and checks each response beat against a local model of the table.
// Depends on sat_pkg and the sorted_array_table RTL only.
`timescale 1ns / 1ps

module tb_sorted_array_table;
    import sat_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    // The slowest beat is a sorted add at index 0 into a nearly full table,
    // plus a receiver stall; this limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;

    // Action code 7 is not used by the block; it must leave the table alone.
    localparam logic [ACT_W-1:0] ACT_UNUSED = ACT_W'(7);

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

    // Clock, reset and every block input start at a known value.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req_item  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic      cfg_data  = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sorted_array_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the table and the mode bits. It advances at each accepted
    // request beat or register write, in the order the block sees them.
    logic [VALUE_WIDTH-1:0] shadow_entries [TABLE_DEPTH];
    int        shadow_count  = 0;
    bit        shadow_sorted = 1'b0;
    bit        shadow_unique = 1'b0;
    bit        shadow_signed = 1'b0;

    req_item_t queued_ops [$];     // request beats waiting for the driver
    rsp_item_t awaited_rsps [$];   // responses owed by the block, oldest first

    int  ops_issued     = 0;
    int  ops_accepted   = 0;
    bit  req_beat_taken = 1'b0;
    int  idle_cycles    = 0;
    int  error_count    = 0;

    int  burst_left = 0;
    int  gap_left   = 0;
    stall_style_t stall_style = STALL_NONE;
    int  stall_span = 0;
    int  stall_tick = 0;

    logic [VALUE_WIDTH-1:0] value_pool [16];

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    // Value order under the current compare mode.
    function automatic bit ranks_below(logic [VALUE_WIDTH-1:0] a, logic [VALUE_WIDTH-1:0] b);
        if (shadow_signed)
            return $signed(a) < $signed(b);
        return a < b;
    endfunction

    // Unsorted mode scans for the lowest match; sorted mode does a lower-bound
    // binary search, even when the table has been knocked out of order.
    // Returns whether the value sits at pos; otherwise pos is the insertion point.
    function automatic bit find_slot(logic [VALUE_WIDTH-1:0] v, output int pos);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count;
        if (!shadow_sorted)
        begin
            for (int i = 0; i < shadow_count; i++)
            begin
                if (shadow_entries[i] == v)
                begin
                    pos = i;
                    return 1'b1;
                end
            end
            pos = shadow_count;
            return 1'b0;
        end
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (ranks_below(shadow_entries[mid], v))
                lo = mid + 1;
            else
                hi = mid;
        end
        pos = lo;
        return (lo < shadow_count) && (shadow_entries[lo] == v);
    endfunction

    function automatic void shift_in(int at, logic [VALUE_WIDTH-1:0] v);
        for (int i = shadow_count; i > at; i--)
            shadow_entries[i] = shadow_entries[i - 1];
        shadow_entries[at] = v;
        shadow_count++;
    endfunction

    // Applies one request to the local table and returns the response it owes.
    function automatic rsp_item_t run_table_op(req_item_t op);
        rsp_item_t              res;
        logic [VALUE_WIDTH-1:0] v;
        int                     pos;
        bit                     hit;
        bit                     is_full;
        res     = '0;
        v       = op.value[VALUE_WIDTH-1:0];
        pos     = 0;
        is_full = (shadow_count >= TABLE_DEPTH);
        case (op.action)
            ACT_READ:
            begin
                if (op.index >= shadow_count)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    res.read_value   = shadow_entries[op.index];
                    res.result_index = op.index;
                end
            end
            ACT_OVERWRITE:
            begin
                if (op.index >= shadow_count)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    shadow_entries[op.index] = v;
                    res.result_index = op.index;
                end
            end
            ACT_INSERT:
            begin
                if (op.index > shadow_count)
                    res.status = ST_RANGE;
                else if (is_full)
                    res.status = ST_FULL;
                else
                begin
                    shift_in(op.index, v);
                    res.result_index = op.index;
                end
            end
            ACT_APPEND, ACT_ADD:
            begin
                if (op.action == ACT_APPEND && shadow_sorted)
                begin
                    res.status = ST_APPEND_SORTED;
                end
                else if (shadow_sorted)
                begin
                    hit = find_slot(v, pos);
                    if (hit)
                    begin
                        // A duplicate is either refreshed in place or rejected,
                        // and both report where it already sits.
                        if (shadow_unique)
                            res.status = ST_DUPLICATE;
                        else
                            shadow_entries[pos] = v;
                        res.result_index = IDX_W'(pos);
                    end
                    else if (is_full)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        shift_in(pos, v);
                        res.result_index = IDX_W'(pos);
                    end
                end
                else if (is_full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    res.result_index = IDX_W'(shadow_count);
                    shift_in(shadow_count, v);
                end
            end
            ACT_REMOVE:
            begin
                if (op.index >= shadow_count)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    for (int i = op.index; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                    res.result_index = op.index;
                end
            end
            ACT_FIND:
            begin
                if (!find_slot(v, pos))
                    res.status = ST_NOT_FOUND;
                res.result_index = IDX_W'(pos);
            end
            default: ;
        endcase
        res.entry_count_out = IDX_W'(shadow_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic req_item_t make_op(logic [ACT_W-1:0] action, int index,
                                          logic [FIELD_VAL_W-1:0] value);
        req_item_t op;
        op.action = action;
        op.index  = IDX_W'(index);
        op.value  = value;
        return op;
    endfunction

    // Values lean on a small pool so that duplicates and matches are common,
    // with neighbors of pool values to land right beside existing entries.
    function automatic logic [FIELD_VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return value_pool[$urandom_range(0, 15)];
            1:       return $urandom();
            2:       return $urandom_range(0, 40);
            default: return value_pool[$urandom_range(0, 15)] + $urandom_range(0, 2) - 1;
        endcase
    endfunction

    // One random request. While growing, most beats add entries; otherwise
    // most remove them, so the count walks between empty and full.
    function automatic req_item_t next_random_op(bit growing);
        req_item_t op;
        int        len;
        len       = shadow_count;
        op.index  = IDX_W'($urandom_range(0, 127));
        op.value  = $urandom();
        if ($urandom_range(0, 99) < 55)
        begin
            if (!growing)
                op.action = ACT_REMOVE;
            else if (shadow_sorted)
                op.action = ($urandom_range(0, 19) != 0) ? ACT_ADD :
                            ($urandom_range(0, 1) != 0)  ? ACT_APPEND : ACT_INSERT;
            else
                case ($urandom_range(0, 2))
                    0:       op.action = ACT_INSERT;
                    1:       op.action = ACT_APPEND;
                    default: op.action = ACT_ADD;
                endcase
        end
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:       op.action = ACT_READ;
                6, 7, 8, 9, 10, 11, 12: op.action = ACT_FIND;
                13:                     op.action = ACT_UNUSED;
                default:
                    // Overwrites break the order of a sorted table; keep them rare there.
                    op.action = (shadow_sorted && $urandom_range(0, 2) != 0) ?
                                ACT_FIND : ACT_OVERWRITE;
            endcase
        end
        // Mostly in-range indexes; the rest stays random across the whole field.
        if ($urandom_range(0, 9) != 0)
        begin
            if (op.action == ACT_INSERT)
                op.index = IDX_W'($urandom_range(0, len));
            else
                op.index = (len == 0) ? IDX_W'(0) : IDX_W'($urandom_range(0, len - 1));
        end
        if ((op.action == ACT_FIND || op.action == ACT_ADD) && len > 0 &&
            $urandom_range(0, 1) != 0)
            op.value = shadow_entries[$urandom_range(0, len - 1)];
        else if (op.action != ACT_READ && op.action != ACT_UNUSED && $urandom_range(0, 4) != 0)
            op.value = pick_value();
        return op;
    endfunction

    task automatic queue_op(req_item_t op);
        queued_ops.push_back(op);
        ops_issued++;
    endtask

    // Holds the sender until every queued beat went in and every response came
    // back, then gives the block time to settle back to idle.
    task automatic wait_idle();
        while (ops_accepted != ops_issued || awaited_rsps.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic program_modes(bit sorted_on, bit unique_on, bit signed_on);
        write_reg(CFG_SORTED, sorted_on);
        write_reg(CFG_UNIQUE, unique_on);
        write_reg(CFG_SIGNED, signed_on);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One phase of random traffic under fixed modes. With clear_first the
    // table is emptied by removes at random positions so that a sorted phase
    // starts from a well-ordered table.
    task automatic run_phase(bit sorted_on, bit unique_on, bit signed_on,
                             bit clear_first, int n_ops);
        int left;
        int seg;
        bit growing;
        wait_idle();
        program_modes(sorted_on, unique_on, signed_on);
        if (clear_first)
        begin
            left = shadow_count;
            while (left > 0)
            begin
                queue_op(make_op(ACT_REMOVE, $urandom_range(0, left - 1), $urandom()));
                left--;
            end
        end
        growing = 1'b1;
        seg     = $urandom_range(40, 120);
        for (int k = 0; k < n_ops; k++)
        begin
            if (seg == 0)
            begin
                growing = !growing;
                seg     = $urandom_range(40, 120);
            end
            // Generate just ahead of the driver so the model's count is current.
            while (queued_ops.size() >= 2)
                @(negedge clk);
            queue_op(next_random_op(growing));
            seg--;
        end
    endtask

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected 'h%0h, got 'h%0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of beats with random gaps. A beat stays on the
    // bus until it is taken; the next one follows at the falling edge unless a gap is due.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!req_valid || req_beat_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (queued_ops.size() > 0)
            begin
                req_item  <= queued_ops.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response stall: the style changes at random intervals, and one of
    // the styles never stalls at all.
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_span  = $urandom_range(50, 300);
        end
        stall_span--;
        stall_tick++;
        case (stall_style)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: rsp_stall <= ((stall_tick % 7) < 3);
            default:        rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, register writes and request beats update
    // the model, response beats are checked, and the watchdog advances.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        rsp_item_t want;
        bit        rsp_beat;
        req_beat_taken = (req_valid === 1'b1) && (req_stall === 1'b0);
        rsp_beat       = rst_n && (rsp_valid === 1'b1) && (rsp_stall === 1'b0);

        if (cfg_valid && cfg_ready === 1'b1)
        begin
            case (cfg_index)
                CFG_SORTED: shadow_sorted = cfg_data;
                CFG_UNIQUE: shadow_unique = cfg_data;
                CFG_SIGNED: shadow_signed = cfg_data;
                default: ;
            endcase
        end

        if (req_beat_taken)
        begin
            awaited_rsps.push_back(run_table_op(req_item));
            ops_accepted++;
        end

        if (rsp_beat)
        begin
            if (awaited_rsps.size() == 0)
            begin
                error_count++;
                $display("%0t: response beat with none expected, got %p", $time, rsp_item);
            end
            else
            begin
                want = awaited_rsps.pop_front();
                report_field("status", 32'(want.status), 32'(rsp_item.status));
                report_field("result_index", 32'(want.result_index),
                             32'(rsp_item.result_index));
                report_field("read_value", want.read_value, rsp_item.read_value);
                report_field("entry_count_out", 32'(want.entry_count_out),
                             32'(rsp_item.entry_count_out));
            end
        end

        if (!rst_n || req_beat_taken || rsp_beat || (cfg_valid && cfg_ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_sorted_array_table failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        value_pool[5] = 32'h8000_0001;
        for (int i = 6; i < 16; i++)
            value_pool[i] = $urandom();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats in plain unsorted, unsigned mode: read, remove, overwrite,
        // find and insert on an empty table, growth at the end, the extreme
        // values, indexes past the count and the unused action code.
        program_modes(1'b0, 1'b0, 1'b0);
        queue_op(make_op(ACT_READ,      0,   32'h0000_0000));
        queue_op(make_op(ACT_REMOVE,    0,   32'h0000_0000));
        queue_op(make_op(ACT_OVERWRITE, 0,   32'hA5A5_A5A5));
        queue_op(make_op(ACT_FIND,      0,   32'h0000_0000));
        queue_op(make_op(ACT_INSERT,    1,   32'h0000_0001));
        queue_op(make_op(ACT_INSERT,    0,   32'hFFFF_FFFF));
        queue_op(make_op(ACT_APPEND,    127, 32'h0000_0000));
        queue_op(make_op(ACT_ADD,       0,   32'h8000_0000));
        queue_op(make_op(ACT_APPEND,    64,  32'h7FFF_FFFF));
        queue_op(make_op(ACT_READ,      3,   32'hFFFF_FFFF));
        queue_op(make_op(ACT_READ,      0,   32'h0000_0000));
        queue_op(make_op(ACT_OVERWRITE, 1,   32'h1234_5678));
        queue_op(make_op(ACT_FIND,      0,   32'h1234_5678));
        queue_op(make_op(ACT_FIND,      0,   32'hDEAD_BEEF));
        queue_op(make_op(ACT_INSERT,    4,   32'h0000_0005));
        queue_op(make_op(ACT_REMOVE,    2,   32'h0000_0000));
        queue_op(make_op(ACT_REMOVE,    3,   32'h0000_0000));
        queue_op(make_op(ACT_READ,      127, 32'h0000_0000));
        queue_op(make_op(ACT_READ,      64,  32'h0000_0000));
        queue_op(make_op(ACT_UNUSED,    85,  32'hFFFF_FFFF));
        queue_op(make_op(ACT_FIND,      0,   32'h7FFF_FFFF));

        // Random phases. Each one first drains every outstanding response,
        // then changes the modes. Some phases without a clear run searches over a
        // table whose order no longer matches the mode.
        run_phase(1'b0, 1'b0, 1'b0, 1'b0, 250);
        run_phase(1'b1, 1'b0, 1'b0, 1'b1, 250);
        run_phase(1'b1, 1'b1, 1'b1, 1'b1, 250);
        run_phase(1'b1, 1'b0, 1'b1, 1'b0, 150);
        run_phase(1'b0, 1'b1, 1'b1, 1'b0, 150);
        run_phase(1'b1, 1'b1, 1'b0, 1'b0, 150);
        run_phase(1'b1, 1'b1, 1'b0, 1'b1, 200);

        // Let the last response arrive, then watch for stray beats a while.
        while (ops_accepted != ops_issued || awaited_rsps.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (awaited_rsps.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d responses never arrived", $time, awaited_rsps.size());
        end

        if (error_count == 0)
            $display("tb_sorted_array_table passed");
        else
            $display("tb_sorted_array_table failed");
        $finish;
    end

endmodule
